@@ design/msx_pkg.sv @@
// Shared types and constants for the MIDI sysex parameter message framer.
// No dependencies; used by the framer top level.
package msx_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE_HEADER  = 2'd0,
    CMD_WRITE_BYTE    = 2'd1,
    CMD_READ_REQUEST  = 2'd2,
    CMD_WRITE_CLOSE   = 2'd3
  } cmd_t;

  localparam logic [1:0] REG_DEVICE_ID = 2'd0;
  localparam logic [1:0] REG_MODEL_ID  = 2'd1;

  localparam logic [6:0]  DEVICE_ID_RESET = 7'd16;
  localparam logic [15:0] MODEL_ID_RESET  = 16'd107;

  localparam logic [7:0] SYX_START = 8'hF0;
  localparam logic [7:0] SYX_END   = 8'hF7;
  localparam logic [7:0] MAKER_ID  = 8'h41;
  localparam logic [7:0] CMD_DT1   = 8'h12;
  localparam logic [7:0] CMD_RQ1   = 8'h11;

  localparam logic [3:0] HDR_LAST_IDX   = 4'd9;
  localparam logic [3:0] RQ_LAST_IDX    = 4'd15;
  localparam logic [3:0] BYTE_LAST_IDX  = 4'd0;
  localparam logic [3:0] TAIL_LAST_IDX  = 4'd2;
  localparam logic [3:0] CLOSE_LAST_IDX = 4'd1;

endpackage

@@ design/midi_sysex_param_message_framer.sv @@
// Top level of the MIDI sysex parameter message framer.
// Depends on msx_pkg for command codes, register indexes and byte constants.
//
// Usage: each beat on the s_ channel carries one command (write header, write
// byte, read request, write close). The block turns it into a run of output
// bytes on the m_ channel, one byte per beat, with m_tlast marking the final
// byte of the run. A write byte or write close with no write frame open is
// taken and produces no bytes. The cfg channel writes device_id (index 0) and
// model_id (index 1); it is always ready and is meant to be used while idle.
// The command beat is registered into the serializer, and the first byte of its
// run then moves into the output register. The block puts out one byte per cycle
// while the receiver does not stall; a run has 10 bytes for a header, 16 for a
// read request, 1 or 3 for a write byte and 2 for a close, and an ignored command
// is simply taken. The next command is taken in the cycle its predecessor's last
// byte moves into the output register, so runs follow back to back.
// Reset clears the open frame, the running checksum, any run in progress and
// the output register, and restores the register defaults. When the receiver
// stalls, the output beat holds and the serializer waits, which in turn holds
// off s_tready while a run is in progress.
module midi_sysex_param_message_framer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // Fields from bit 0: command[1:0], address[33:2], data_byte[41:34],
  // request_size[73:42], zero pad[79:74].
  input  logic [79:0] s_tdata,
  // last_byte.
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // Fields from bit 0: out_byte[7:0].
  output logic [7:0]  m_tdata,
  // run_end.
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [6:0]  device_id;
  logic [15:0] model_id;
  logic [6:0]  running_sum;
  logic        frame_open;

  logic                cur_valid;
  msx_pkg::cmd_t       cur_cmd;
  logic [31:0]         cur_address;
  logic [7:0]          cur_data;
  logic [31:0]         cur_size;
  logic [6:0]          cur_cks;
  logic [3:0]          idx;
  logic [3:0]          last_idx;

  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;

  msx_pkg::cmd_t in_cmd;
  logic [31:0]   in_address;
  logic [7:0]    in_data;
  logic [31:0]   in_size;
  logic          in_fire;
  logic          in_load;
  logic          adv;
  logic          run_done;
  logic [7:0]    next_byte;

  logic [10:0] base_sum;
  logic [10:0] size_sum;
  logic [6:0]  hdr_sum;
  logic [6:0]  rq_sum;
  logic [6:0]  byte_sum;

  assign cfg_ready = 1'b1;

  assign in_cmd     = msx_pkg::cmd_t'(s_tdata[1:0]);
  assign in_address = s_tdata[33:2];
  assign in_data    = s_tdata[41:34];
  assign in_size    = s_tdata[73:42];

  assign adv      = cur_valid && (!out_valid || m_tready);
  assign run_done = adv && (idx == last_idx);
  assign s_tready = !cur_valid || run_done;
  assign in_fire  = s_tvalid && s_tready;
  assign in_load  = in_fire && ((in_cmd == msx_pkg::CMD_WRITE_HEADER) ||
                                (in_cmd == msx_pkg::CMD_READ_REQUEST) || frame_open);

  assign base_sum = {4'd0, device_id} + {4'd0, model_id[14:8]} + {4'd0, model_id[6:0]} +
                    {4'd0, in_address[30:24]} + {4'd0, in_address[22:16]} +
                    {4'd0, in_address[14:8]} + {4'd0, in_address[6:0]};
  assign size_sum = {4'd0, in_size[30:24]} + {4'd0, in_size[22:16]} +
                    {4'd0, in_size[14:8]} + {4'd0, in_size[6:0]};
  assign hdr_sum  = base_sum[6:0] + msx_pkg::CMD_DT1[6:0];
  assign rq_sum   = base_sum[6:0] + msx_pkg::CMD_RQ1[6:0] + size_sum[6:0];
  assign byte_sum = running_sum + in_data[6:0];

  always_comb begin
    next_byte = msx_pkg::SYX_END;
    case (cur_cmd)
      msx_pkg::CMD_WRITE_HEADER, msx_pkg::CMD_READ_REQUEST: begin
        case (idx)
          4'd0:    next_byte = msx_pkg::SYX_START;
          4'd1:    next_byte = msx_pkg::MAKER_ID;
          4'd2:    next_byte = {1'b0, device_id};
          4'd3:    next_byte = model_id[15:8];
          4'd4:    next_byte = model_id[7:0];
          4'd5:    next_byte = (cur_cmd == msx_pkg::CMD_WRITE_HEADER) ?
                               msx_pkg::CMD_DT1 : msx_pkg::CMD_RQ1;
          4'd6:    next_byte = cur_address[31:24];
          4'd7:    next_byte = cur_address[23:16];
          4'd8:    next_byte = cur_address[15:8];
          4'd9:    next_byte = cur_address[7:0];
          4'd10:   next_byte = cur_size[31:24];
          4'd11:   next_byte = cur_size[23:16];
          4'd12:   next_byte = cur_size[15:8];
          4'd13:   next_byte = cur_size[7:0];
          4'd14:   next_byte = {1'b0, cur_cks};
          default: next_byte = msx_pkg::SYX_END;
        endcase
      end
      msx_pkg::CMD_WRITE_BYTE: begin
        case (idx)
          4'd0:    next_byte = cur_data;
          4'd1:    next_byte = {1'b0, cur_cks};
          default: next_byte = msx_pkg::SYX_END;
        endcase
      end
      default: begin
        next_byte = (idx == 4'd0) ? {1'b0, cur_cks} : msx_pkg::SYX_END;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_id <= msx_pkg::DEVICE_ID_RESET;
      model_id  <= msx_pkg::MODEL_ID_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        msx_pkg::REG_DEVICE_ID: device_id <= cfg_data[6:0];
        msx_pkg::REG_MODEL_ID:  model_id  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= 7'd0;
      frame_open  <= 1'b0;
      cur_valid   <= 1'b0;
      idx         <= 4'd0;
      last_idx    <= 4'd0;
      cur_cmd     <= msx_pkg::CMD_WRITE_HEADER;
    end else begin
      if (in_load) begin
        cur_valid <= 1'b1;
        idx       <= 4'd0;
        cur_cmd   <= in_cmd;
        case (in_cmd)
          msx_pkg::CMD_WRITE_HEADER: begin
            running_sum <= hdr_sum;
            frame_open  <= 1'b1;
            last_idx    <= msx_pkg::HDR_LAST_IDX;
          end
          msx_pkg::CMD_WRITE_BYTE: begin
            if (s_tlast) begin
              running_sum <= 7'd0;
              frame_open  <= 1'b0;
              last_idx    <= msx_pkg::TAIL_LAST_IDX;
            end else begin
              running_sum <= byte_sum;
              last_idx    <= msx_pkg::BYTE_LAST_IDX;
            end
          end
          msx_pkg::CMD_READ_REQUEST: begin
            last_idx <= msx_pkg::RQ_LAST_IDX;
          end
          default: begin
            running_sum <= 7'd0;
            frame_open  <= 1'b0;
            last_idx    <= msx_pkg::CLOSE_LAST_IDX;
          end
        endcase
      end else if (run_done) begin
        cur_valid <= 1'b0;
      end else if (adv) begin
        idx <= idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      cur_address <= in_address;
      cur_data    <= in_data;
      cur_size    <= in_size;
      case (in_cmd)
        msx_pkg::CMD_WRITE_BYTE:   cur_cks <= 7'd0 - byte_sum;
        msx_pkg::CMD_READ_REQUEST: cur_cks <= 7'd0 - rq_sum;
        default:                   cur_cks <= 7'd0 - running_sum;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte <= next_byte;
      out_last <= (idx == last_idx);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tlast  = out_last;

endmodule

@@ design/midi_sysex_param_message_framer_checker.sv @@
// Port-level checker for the MIDI sysex parameter message framer.
// Depends only on the framer's ports; bound to the top level below.
module midi_sysex_param_message_framer_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast,
  input logic        cfg_ready
);

  // A beat that is stalled holds its byte and its run marker.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("output beat changed while stalled");

  // Reset empties the output register.
  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Reset leaves no run in progress, so a command is taken at once.
  a_rst_in: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  // The register port never pushes back.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind midi_sysex_param_message_framer midi_sysex_param_message_framer_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tlast   (m_tlast),
  .cfg_ready (cfg_ready)
);

@@ bench/tb_midi_sysex_param_message_framer.sv @@
// Self-checking testbench for midi_sysex_param_message_framer: drives command beats, predicts
// the sysex byte stream in a scoreboard class and checks every output beat in order.
// Depends on msx_pkg and the framer top level only.
`timescale 1ns / 1ps

module tb_midi_sysex_param_message_framer;

  localparam logic [1:0] REG_SPARE_LO = 2'd2;
  localparam logic [1:0] REG_SPARE_HI = 2'd3;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic [7:0] value;
    logic       run_end;
  } stream_beat_t;

  class sysex_frame_tracker;
    logic [6:0]   device_id;
    logic [15:0]  model_id;
    logic [6:0]   write_sum;
    logic [6:0]   acc;
    bit           frame_open;
    int           errors;
    stream_beat_t expected_q[$];

    function new();
      device_id = msx_pkg::DEVICE_ID_RESET;
      model_id = msx_pkg::MODEL_ID_RESET;
      write_sum = 7'd0;
      acc = 7'd0;
      frame_open = 1'b0;
      errors = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [15:0] value);
      case (idx)
        msx_pkg::REG_DEVICE_ID: device_id = value[6:0];
        msx_pkg::REG_MODEL_ID: model_id = value;
        default: ;
      endcase
    endfunction

    function void put(logic [7:0] value);
      stream_beat_t b;
      b.value = value;
      b.run_end = 1'b0;
      expected_q.push_back(b);
    endfunction

    function void put_summed(logic [7:0] value);
      put(value);
      acc = acc + value[6:0];
    endfunction

    function void put_head(logic [7:0] kind, logic [31:0] addr);
      acc = 7'd0;
      put(msx_pkg::SYX_START);
      put(msx_pkg::MAKER_ID);
      put_summed({1'b0, device_id});
      put_summed(model_id[15:8]);
      put_summed(model_id[7:0]);
      put_summed(kind);
      for (int k = 3; k >= 0; k--) put_summed(addr[8*k +: 8]);
    endfunction

    function void put_tail();
      put({1'b0, 7'd0 - acc});
      put(msx_pkg::SYX_END);
    endfunction

    function int take_command(msx_pkg::cmd_t cmd, logic [31:0] addr, logic [7:0] data,
                              logic last, logic [31:0] size);
      int first;
      stream_beat_t b;
      first = expected_q.size();
      case (cmd)
        msx_pkg::CMD_WRITE_HEADER: begin
          put_head(msx_pkg::CMD_DT1, addr);
          write_sum = acc;
          frame_open = 1'b1;
        end
        msx_pkg::CMD_WRITE_BYTE: begin
          if (frame_open) begin
            acc = write_sum;
            put_summed(data);
            write_sum = acc;
            if (last) begin
              put_tail();
              frame_open = 1'b0;
              write_sum = 7'd0;
            end
          end
        end
        msx_pkg::CMD_READ_REQUEST: begin
          put_head(msx_pkg::CMD_RQ1, addr);
          for (int k = 3; k >= 0; k--) put_summed(size[8*k +: 8]);
          put_tail();
        end
        msx_pkg::CMD_WRITE_CLOSE: begin
          if (frame_open) begin
            acc = write_sum;
            put_tail();
            frame_open = 1'b0;
            write_sum = 7'd0;
          end
        end
      endcase
      if (expected_q.size() > first) begin
        b = expected_q.pop_back();
        b.run_end = 1'b1;
        expected_q.push_back(b);
      end
      return expected_q.size() - first;
    endfunction

    task report(string msg);
      errors++;
      $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task check_beat(logic [7:0] value, logic run_end);
      stream_beat_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected beat %02h tlast %0b", value, run_end));
      end else begin
        want = expected_q.pop_front();
        if (value !== want.value)
          report($sformatf("byte %02h, expected %02h", value, want.value));
        if (run_end !== want.run_end)
          report($sformatf("tlast %0b on byte %02h, expected %0b", run_end, value, want.run_end));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = msx_pkg::REG_DEVICE_ID;
  logic [15:0] cfg_data = '0;

  sysex_frame_tracker frames = new();
  int framed_items = 0;
  int idle_cycles = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit hold_request = 1'b0;

  midi_sysex_param_message_framer uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) frames.check_beat(m_tdata, m_tlast);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= rx_steady || ($urandom_range(99) >= 30);
    end
  end

  task automatic send_command(input msx_pkg::cmd_t cmd, input logic [31:0] addr,
                              input logic [7:0] data, input logic last,
                              input logic [31:0] size);
    int produced;
    while (!tx_steady && $urandom_range(99) < 30) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, size, data, addr, cmd};
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    produced = frames.take_command(cmd, addr, data, last, size);
    if (produced > 0) framed_items++;
  endtask

  task automatic cfg_beat(input logic [1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    frames.set_register(idx, value);
  endtask

  task automatic write_settings(input logic [15:0] dev_value, input logic [15:0] model_value);
    cfg_beat(msx_pkg::REG_DEVICE_ID, dev_value);
    cfg_beat(msx_pkg::REG_MODEL_ID, model_value);
    cfg_beat($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (frames.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_write_frame();
    int nbytes;
    bit close_end;
    bit abandon;
    nbytes = ($urandom_range(9) == 0) ? $urandom_range(20, 6) : $urandom_range(4, 0);
    close_end = (nbytes == 0) || ($urandom_range(3) == 0);
    abandon = ($urandom_range(11) == 0);
    send_command(msx_pkg::CMD_WRITE_HEADER, $urandom, 8'($urandom), 1'($urandom), $urandom);
    for (int i = 0; i < nbytes; i++) begin
      if ($urandom_range(9) == 0)
        send_command(msx_pkg::CMD_READ_REQUEST, $urandom, 8'($urandom), 1'($urandom),
                     $urandom);
      send_command(msx_pkg::CMD_WRITE_BYTE, $urandom, 8'($urandom),
                   (i == nbytes - 1) && !close_end && !abandon, $urandom);
    end
    if (close_end && !abandon)
      send_command(msx_pkg::CMD_WRITE_CLOSE, $urandom, 8'($urandom), 1'($urandom), $urandom);
  endtask

  task automatic run_random(input int count);
    int start;
    int pick;
    start = framed_items;
    while (framed_items - start < count) begin
      pick = $urandom_range(99);
      if (pick < 55)
        send_write_frame();
      else if (pick < 75)
        send_command(msx_pkg::CMD_READ_REQUEST, $urandom, 8'($urandom), 1'($urandom),
                     $urandom);
      else
        send_command(msx_pkg::cmd_t'($urandom_range(3)), $urandom, 8'($urandom),
                     1'($urandom), $urandom);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_command(msx_pkg::CMD_WRITE_BYTE, 32'h0, 8'hFF, 1'b1, 32'h0);
    send_command(msx_pkg::CMD_WRITE_CLOSE, 32'hFFFFFFFF, 8'h00, 1'b0, 32'hFFFFFFFF);
    send_command(msx_pkg::CMD_WRITE_HEADER, 32'h00000000, 8'h00, 1'b0, 32'h0);
    send_command(msx_pkg::CMD_WRITE_BYTE, 32'h0, 8'h00, 1'b0, 32'h0);
    send_command(msx_pkg::CMD_WRITE_BYTE, 32'h0, 8'hFF, 1'b0, 32'h0);
    send_command(msx_pkg::CMD_WRITE_BYTE, 32'h0, 8'h80, 1'b0, 32'h0);
    send_command(msx_pkg::CMD_WRITE_BYTE, 32'h0, 8'h7F, 1'b1, 32'h0);
    send_command(msx_pkg::CMD_WRITE_HEADER, 32'hFFFFFFFF, 8'hFF, 1'b1, 32'hFFFFFFFF);
    send_command(msx_pkg::CMD_WRITE_CLOSE, 32'h0, 8'h00, 1'b1, 32'h0);
    send_command(msx_pkg::CMD_READ_REQUEST, 32'h00000000, 8'h00, 1'b0, 32'h00000000);
    send_command(msx_pkg::CMD_READ_REQUEST, 32'hFFFFFFFF, 8'hFF, 1'b1, 32'hFFFFFFFF);
    send_command(msx_pkg::CMD_WRITE_HEADER, 32'h12345678, 8'h00, 1'b0, 32'h0);
    send_command(msx_pkg::CMD_WRITE_BYTE, 32'h0, 8'h55, 1'b0, 32'h0);
    send_command(msx_pkg::CMD_WRITE_HEADER, 32'h00FF00FF, 8'h00, 1'b0, 32'h0);
    send_command(msx_pkg::CMD_WRITE_BYTE, 32'h0, 8'hAA, 1'b1, 32'h0);
    send_command(msx_pkg::CMD_WRITE_HEADER, 32'h7F7F7F7F, 8'h00, 1'b0, 32'h0);
    send_command(msx_pkg::CMD_WRITE_BYTE, 32'h0, 8'h01, 1'b0, 32'h0);
    send_command(msx_pkg::CMD_READ_REQUEST, 32'h80808080, 8'h00, 1'b0, 32'h01020304);
    send_command(msx_pkg::CMD_WRITE_BYTE, 32'h0, 8'hFE, 1'b0, 32'h0);
    send_command(msx_pkg::CMD_WRITE_CLOSE, 32'h0, 8'h00, 1'b0, 32'h0);
    send_command(msx_pkg::CMD_WRITE_CLOSE, 32'h0, 8'h00, 1'b0, 32'h0);
    send_command(msx_pkg::CMD_WRITE_BYTE, 32'h0, 8'h33, 1'b1, 32'h0);
    wait_idle();

    write_settings(16'h0000, 16'h0000);
    run_random(90);
    wait_idle();

    write_settings(16'hFFFF, 16'hFFFF);
    hold_request = 1'b1;
    tx_steady = 1'b1;
    run_random(40);
    tx_steady = 1'b0;
    run_random(50);
    wait_idle();

    write_settings(16'($urandom), 16'($urandom));
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    run_random(90);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    wait_idle();

    write_settings(16'($urandom), 16'($urandom));
    run_random(90);
    wait_idle();

    write_settings(16'h007F, 16'h8000);
    run_random(80);
    wait_idle();
    repeat (20) @(posedge clk);

    if (frames.pending() != 0)
      frames.report($sformatf("%0d expected bytes never arrived", frames.pending()));
    if (frames.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ files.f @@
design/msx_pkg.sv
design/midi_sysex_param_message_framer.sv
design/midi_sysex_param_message_framer_checker.sv
bench/tb_midi_sysex_param_message_framer.sv
